>>> src/u2l_pkg.sv
// Shared types, constants and helper functions for the UTF-8 to Latin-1 decoder.
`default_nettype none
package u2l_pkg;

  // Longest lead byte accepted (legacy UTF-8 allows up to 6).
  localparam logic [2:0] MAX_SEQUENCE_BYTES = 3'd6;
  localparam logic [7:0] REPLACEMENT_RESET  = 8'h3f;  // '?'
  localparam logic [7:0] LATIN1_MAX         = 8'hff;

  // Decoder sequence state carried between bytes.
  typedef struct packed {
    logic [30:0] acc;
    logic [2:0]  exp_len;
    logic [2:0]  rcvd;
  } seq_state_t;

  // Results caused by one byte: reps replacements, then an optional tail item.
  typedef struct packed {
    logic [2:0] reps;
    logic       tail;
    logic [7:0] tail_char;
    logic       tail_end;
  } run_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    priority if (b < 8'h80) len = 3'd1;
    else if (b < 8'hc0)     len = 3'd0;
    else if (b < 8'he0)     len = 3'd2;
    else if (b < 8'hf0)     len = 3'd3;
    else if (b < 8'hf8)     len = 3'd4;
    else if (b < 8'hfc)     len = 3'd5;
    else if (b < 8'hfe)     len = 3'd6;
    else                    len = 3'd0;
    if (len > MAX_SEQUENCE_BYTES) len = 3'd0;
    return len;
  endfunction

  // Smallest code point that a sequence of the given length may carry.
  function automatic logic [30:0] min_value(input logic [2:0] len);
    logic [30:0] v;
    unique case (len)
      3'd2:    v = 31'h80;
      3'd3:    v = 31'h800;
      3'd4:    v = 31'h10000;
      3'd5:    v = 31'h200000;
      3'd6:    v = 31'h4000000;
      default: v = 31'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/u2l_step.sv
// Per-byte decode: next sequence state and the run of results the byte causes.
`default_nettype none
module u2l_step
  import u2l_pkg::*;
(
  input  wire logic [7:0] data_byte,
  input  wire seq_state_t st,
  output seq_state_t      st_next,
  output run_t            run
);

  logic [30:0] acc_sh;
  logic [2:0]  rcvd_inc;
  logic [2:0]  len;
  logic        do_fresh;

  always_comb begin
    acc_sh   = {st.acc[24:0], data_byte[5:0]};
    rcvd_inc = st.rcvd + 3'd1;
    len      = lead_length(data_byte);
    st_next  = st;
    run      = '0;
    do_fresh = 1'b0;

    if (st.exp_len != 3'd0) begin
      if (data_byte[7:6] == 2'b10) begin
        st_next.acc  = acc_sh;
        st_next.rcvd = rcvd_inc;
        if (rcvd_inc >= st.exp_len) begin
          st_next = '0;
          if (acc_sh < min_value(st.exp_len)) begin
            run.reps = st.exp_len;                  // overlong: one per byte
          end else if (acc_sh > {23'd0, LATIN1_MAX}) begin
            run.reps = 3'd1;
          end else begin
            run.tail      = 1'b1;
            run.tail_char = acc_sh[7:0];
          end
        end
      end else begin
        // broken sequence: flush what was received, then treat byte as new
        run.reps = st.rcvd;
        st_next  = '0;
        do_fresh = 1'b1;
      end
    end else begin
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      if (data_byte == 8'd0) begin
        st_next      = '0;
        run.tail     = 1'b1;
        run.tail_end = 1'b1;
      end else if (len == 3'd0) begin
        run.reps = run.reps + 3'd1;
      end else if (len == 3'd1) begin
        run.tail      = 1'b1;
        run.tail_char = data_byte;
      end else begin
        st_next.acc     = {23'd0, data_byte & (8'h7f >> len)};
        st_next.exp_len = len;
        st_next.rcvd    = 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/utf8_to_latin1_decoder_top.sv
// Top level of the streaming UTF-8 to ISO-8859-1 decoder.
// Takes one UTF-8 byte per transaction and gives zero to six Latin-1 results
// for it; tlast marks the final result caused by each input byte. A byte that
// causes at most one result is taken every cycle, back to back, as long as the
// previous result is taken in the same cycle; s_axis_tready follows
// m_axis_tready combinationally. A byte causing N results (error flushes)
// occupies the result register until all N are taken, and the input stalls
// until the last of them is being taken. A zero byte ends the string with a NUL
// result flagged in tuser. The replacement byte resets to '?' and may be
// rewritten over the cfg channel while the block is idle.
`default_nettype none
module utf8_to_latin1_decoder_top
  import u2l_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,        // [7:0] replacement_char
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // [7:0] data_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,    // [7:0] iso_char
  output logic [1:0]      m_axis_tuser,    // [0] replaced, [1] end_of_string
  output logic            m_axis_tlast     // last_of_run
);

  seq_state_t st, st_next;
  run_t       run;
  logic [7:0] replacement_char;

  // pending results of the current run
  logic       out_valid;
  logic [2:0] reps;
  logic       tail;
  logic [7:0] tail_char;
  logic       tail_end;

  logic in_fire, out_fire, last_now, has_out;

  u2l_step u_step (
    .data_byte (s_axis_tdata),
    .st        (st),
    .st_next   (st_next),
    .run       (run)
  );

  assign cfg_ready = 1'b1;

  assign last_now      = (reps == 3'd0) || (reps == 3'd1 && !tail);
  assign out_fire      = out_valid && m_axis_tready;
  assign s_axis_tready = !out_valid || (m_axis_tready && last_now);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign has_out       = (run.reps != 3'd0) || run.tail;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = last_now;
  assign m_axis_tdata  = (reps != 3'd0) ? replacement_char : tail_char;
  assign m_axis_tuser  = (reps != 3'd0) ? 2'b01 : {tail_end, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_char <= REPLACEMENT_RESET;
    end else if (cfg_valid) begin
      replacement_char <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      reps      <= 3'd0;
      tail      <= 1'b0;
    end else if (in_fire) begin
      out_valid <= has_out;
      reps      <= run.reps;
      tail      <= run.tail;
    end else if (out_fire) begin
      if (last_now) begin
        out_valid <= 1'b0;
        reps      <= 3'd0;
        tail      <= 1'b0;
      end else begin
        reps <= reps - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tail_char <= run.tail_char;
      tail_end  <= run.tail_end;
    end
  end

endmodule
`default_nettype wire
